// ===== hdl/lsp_pkg.sv =====
// Shared types, constants and the square root step function for the lidar spherical projection pipeline.
package lsp_pkg;

  localparam int SQ_RW   = 32;
  localparam int SQ_REMW = SQ_RW + 3;
  localparam int SQ_STEPS = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int CRD_W = 36;
  localparam int ANG_W = 34;
  localparam int FOV_W = 16;
  localparam int DN_W  = 15;
  localparam int ROW_W = 6;
  localparam int COL_W = 11;
  localparam int PIX_W = 17;
  localparam int DIST_W = 24;

  localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sd1073741824;
  localparam logic signed [15:0] PITCH_SCALE = 16'sd18000;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    34'sd268435456, 34'sd158466703, 34'sd83729454, 34'sd42502378, 34'sd21333666,
    34'sd10677233, 34'sd5339919, 34'sd2670123, 34'sd1335082, 34'sd667543,
    34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430,
    34'sd5215, 34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41
  };

  typedef enum logic [1:0] {
    REG_FOV_UP   = 2'd0,
    REG_FOV_LO   = 2'd1,
    REG_ROWS     = 2'd2,
    REG_COLS     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0] refl;
    logic [19:0] pnum;
  } item_t;

  typedef struct packed {
    item_t it;
    logic [DIST_W-1:0] radius;
  } side_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] yaw;
    logic yaw_zero;
    logic signed [ANG_W-1:0] pitch;
  } ang_t;

  typedef struct packed {
    logic [FOV_W-1:0] fov;
    logic signed [FOV_W:0] fov_dn;
    logic fov_zero;
  } map_cfg_t;

  typedef struct packed {
    logic [SQ_REMW-1:0] rem;
    logic [SQ_RW-1:0] root;
  } sq_t;

  function automatic sq_t sq_step(sq_t s, logic [1:0] b);
    sq_t o;
    logic [SQ_REMW-1:0] r;
    logic [SQ_REMW-1:0] t;
    r = {s.rem[SQ_REMW-3:0], b};
    t = {1'b0, s.root, 2'b01};
    if (r >= t) begin
      o.rem = r - t;
      o.root = {s.root[SQ_RW-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.root = {s.root[SQ_RW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== hdl/lidar_spherical_projection_unit.sv =====
// Top level of the lidar spherical projection unit: config port, input squares, output register.
//
// Input channel (in_*): one lidar point per beat, x/y/z in mm, reflectance, point number.
// Output channel (out_*): pixel index, column, row, range and the point fields.
// A point at the origin produces no output beat; every other point produces one.
// Throughput: one point per cycle unless out_ready stalls the output. All stages advance together.
// From input beat to output beat a point passes the squares and sums, the root
// stages, the CORDIC, the mapping stages, the divider stages for the row quotient
// bits, the row select and the output register holding the pixel index.
// When out_ready is low with a beat waiting, the whole pipeline holds and in_ready
// drops; nothing is lost or repeated. in_ready is high whenever the output register
// is empty or being drained.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
// Registers (APB, byte address 4*i): upper and lower FOV limits (centidegrees),
// image_rows, image_cols. Write them only while the pipeline is empty.
module lidar_spherical_projection_unit import lsp_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 2048
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0] in_reflectance,
  input  logic [19:0] in_point_number,
  output logic out_valid,
  input  logic out_ready,
  output logic [PIX_W-1:0] out_pixel_index,
  output logic [COL_W-1:0] out_col,
  output logic [ROW_W-1:0] out_row,
  output logic [DIST_W-1:0] out_distance,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic [15:0] out_reflectance,
  output logic [19:0] out_point_number,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int RCW = $clog2(MAX_ROWS+1);
  localparam int CW  = $clog2(MAX_COLS+1);
  localparam int QW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CVW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FRW = FOV_W + RCW;

  logic signed [14:0] fov_up_r, fov_lo_r;
  logic [6:0] rows_r;
  logic [11:0] cols_r;

  map_cfg_t mcfg_r;
  logic [RCW-1:0] rows_eff_r, rows_nxt;
  logic [CW-1:0] cols_eff_r, cols_nxt;
  logic [FRW-1:0] fov_rows_r;
  logic signed [FOV_W-1:0] fov_diff, dn_s;
  logic [FOV_W-1:0] fov_nxt;

  logic en;
  logic v0_r, v1_r;
  item_t it0_r, it1_r, it_in;
  logic signed [47:0] sx_r, sy_r, sz_r;
  logic [2*SQ_RW-1:0] rh1_r, rd1_r;
  logic [47:0] sxy;

  logic sq_v;
  side_t sq_side;
  logic [SQ_RW-1:0] sq_horiz;
  logic cd_v;
  side_t cd_side;
  ang_t cd_ang;
  logic mp_v;
  side_t mp_side;
  logic [CVW-1:0] mp_col;
  logic [QW-1:0] mp_row;

  logic out_valid_r;
  logic [PIX_W-1:0] pix_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  side_t side_r;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fov_up_r <= 15'sd300;
      fov_lo_r <= -15'sd2500;
      rows_r <= 7'd64;
      cols_r <= 12'd2048;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_FOV_UP:   fov_up_r <= pwdata[14:0];
        REG_FOV_LO:   fov_lo_r <= pwdata[14:0];
        REG_ROWS:     rows_r <= pwdata[6:0];
        REG_COLS:     cols_r <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_FOV_UP:   prdata = {17'b0, fov_up_r};
      REG_FOV_LO:   prdata = {17'b0, fov_lo_r};
      REG_ROWS:     prdata = {25'b0, rows_r};
      REG_COLS:     prdata = {20'b0, cols_r};
    endcase
  end

  assign fov_diff = FOV_W'(fov_up_r) - FOV_W'(fov_lo_r);
  assign fov_nxt = (fov_diff < 0) ? FOV_W'(-fov_diff) : FOV_W'(fov_diff);
  assign dn_s = (fov_lo_r < 0) ? -FOV_W'(fov_lo_r) : FOV_W'(fov_lo_r);

  always_comb begin
    if (rows_r == '0) begin
      rows_nxt = RCW'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      rows_nxt = RCW'(MAX_ROWS);
    end else begin
      rows_nxt = RCW'(rows_r);
    end
    if (cols_r == '0) begin
      cols_nxt = CW'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      cols_nxt = CW'(MAX_COLS);
    end else begin
      cols_nxt = CW'(cols_r);
    end
  end

  always_ff @(posedge clk) begin
    mcfg_r.fov <= fov_nxt;
    mcfg_r.fov_dn <= $signed({1'b0, fov_nxt}) - $signed({2'b00, dn_s[DN_W-1:0]});
    mcfg_r.fov_zero <= fov_nxt == '0;
    rows_eff_r <= rows_nxt;
    cols_eff_r <= cols_nxt;
    fov_rows_r <= FRW'(fov_nxt) * FRW'(rows_nxt);
  end

  // input squares
  assign en = !out_valid_r || out_ready;
  assign in_ready = en;
  assign it_in = '{x: in_pos_x, y: in_pos_y, z: in_pos_z,
                   refl: in_reflectance, pnum: in_point_number};
  assign sxy = sx_r[47:0] + sy_r[47:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid && !((in_pos_x == '0) && (in_pos_y == '0) && (in_pos_z == '0));
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0_r <= it_in;
      sx_r <= in_pos_x * in_pos_x;
      sy_r <= in_pos_y * in_pos_y;
      sz_r <= in_pos_z * in_pos_z;
      it1_r <= it0_r;
      rh1_r <= {sxy, 16'b0};
      rd1_r <= (2*SQ_RW)'(sxy) + (2*SQ_RW)'(sz_r[47:0]);
    end
  end

  lsp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v1_r), .in_item(it1_r), .in_rad_h(rh1_r), .in_rad_d(rd1_r),
    .out_valid(sq_v), .out_side(sq_side), .out_horiz(sq_horiz)
  );

  lsp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sq_v), .in_side(sq_side), .in_horiz(sq_horiz),
    .out_valid(cd_v), .out_side(cd_side), .out_ang(cd_ang)
  );

  lsp_map #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_map (
    .clk(clk), .rst_n(rst_n), .en(en),
    .cfg(mcfg_r), .rows(rows_eff_r), .cols(cols_eff_r), .fov_rows(fov_rows_r),
    .in_valid(cd_v), .in_side(cd_side), .in_ang(cd_ang),
    .out_valid(mp_v), .out_side(mp_side), .out_col(mp_col), .out_row(mp_row)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= PIX_W'((QW+CW+1)'(mp_row) * (QW+CW+1)'(cols_eff_r) + (QW+CW+1)'(mp_col));
      col_r <= COL_W'(mp_col);
      row_r <= ROW_W'(mp_row);
      side_r <= mp_side;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel_index = pix_r;
  assign out_col = col_r;
  assign out_row = row_r;
  assign out_distance = side_r.radius;
  assign out_x = side_r.it.x;
  assign out_y = side_r.it.y;
  assign out_z = side_r.it.z;
  assign out_reflectance = side_r.it.refl;
  assign out_point_number = side_r.it.pnum;

endmodule

// ===== hdl/lsp_sqrt.sv =====
// Pipelined integer square roots: horizontal range term and full Euclidean range.
module lsp_sqrt import lsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  item_t in_item,
  input  logic [2*SQ_RW-1:0] in_rad_h,
  input  logic [2*SQ_RW-1:0] in_rad_d,
  output logic out_valid,
  output side_t out_side,
  output logic [SQ_RW-1:0] out_horiz
);

  logic v_r [SQ_STEPS];
  item_t it_r [SQ_STEPS];
  logic [2*SQ_RW-1:0] rh_r [SQ_STEPS];
  logic [2*SQ_RW-1:0] rd_r [SQ_STEPS];
  sq_t sh_r [SQ_STEPS];
  sq_t sd_r [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_st
    logic v_s;
    item_t it_s;
    logic [2*SQ_RW-1:0] rh_s, rd_s;
    sq_t sh_s, sd_s;
    if (i == 0) begin : g_src
      assign v_s = in_valid;
      assign it_s = in_item;
      assign rh_s = in_rad_h;
      assign rd_s = in_rad_d;
      assign sh_s = '0;
      assign sd_s = '0;
    end else begin : g_src
      assign v_s = v_r[i-1];
      assign it_s = it_r[i-1];
      assign rh_s = rh_r[i-1];
      assign rd_s = rd_r[i-1];
      assign sh_s = sh_r[i-1];
      assign sd_s = sd_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_s;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        it_r[i] <= it_s;
        rh_r[i] <= {rh_s[2*SQ_RW-3:0], 2'b00};
        rd_r[i] <= {rd_s[2*SQ_RW-3:0], 2'b00};
        sh_r[i] <= sq_step(sh_s, rh_s[2*SQ_RW-1:2*SQ_RW-2]);
        sd_r[i] <= sq_step(sd_s, rd_s[2*SQ_RW-1:2*SQ_RW-2]);
      end
    end
  end

  assign out_valid = v_r[SQ_STEPS-1];
  assign out_side.it = it_r[SQ_STEPS-1];
  assign out_side.radius = sd_r[SQ_STEPS-1].root[DIST_W-1:0];
  assign out_horiz = sh_r[SQ_STEPS-1].root;

endmodule

// ===== hdl/lsp_cordic.sv =====
// Pipelined vectoring CORDIC for yaw and pitch: a quadrant setup stage, then one rotation step per stage.
module lsp_cordic import lsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  side_t in_side,
  input  logic [SQ_RW-1:0] in_horiz,
  output logic out_valid,
  output side_t out_side,
  output ang_t out_ang
);

  localparam int NS = CORDIC_STEPS + 1;

  logic v_r [NS];
  side_t sd_r [NS];
  logic yz_r [NS];
  logic signed [CRD_W-1:0] yx_r [NS];
  logic signed [CRD_W-1:0] yy_r [NS];
  logic signed [ANG_W-1:0] ya_r [NS];
  logic signed [CRD_W-1:0] px_r [NS];
  logic signed [CRD_W-1:0] py_r [NS];
  logic signed [ANG_W-1:0] pa_r [NS];

  logic signed [CRD_W-1:0] xs, ys, zs;

  assign xs = CRD_W'(in_side.it.x) <<< 8;
  assign ys = CRD_W'(in_side.it.y) <<< 8;
  assign zs = CRD_W'(in_side.it.z) <<< 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= in_side;
      yz_r[0] <= (in_side.it.x == '0) && (in_side.it.y == '0);
      if (in_side.it.x < 0) begin
        yx_r[0] <= -xs;
        yy_r[0] <= -ys;
        ya_r[0] <= (in_side.it.y >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        yx_r[0] <= xs;
        yy_r[0] <= ys;
        ya_r[0] <= '0;
      end
      px_r[0] <= CRD_W'(in_horiz);
      py_r[0] <= zs;
      pa_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[i+1] <= sd_r[i];
        yz_r[i+1] <= yz_r[i];
        if (yy_r[i] < 0) begin
          yx_r[i+1] <= yx_r[i] - (yy_r[i] >>> i);
          yy_r[i+1] <= yy_r[i] + (yx_r[i] >>> i);
          ya_r[i+1] <= ya_r[i] - ATAN_TAB[i];
        end else begin
          yx_r[i+1] <= yx_r[i] + (yy_r[i] >>> i);
          yy_r[i+1] <= yy_r[i] - (yx_r[i] >>> i);
          ya_r[i+1] <= ya_r[i] + ATAN_TAB[i];
        end
        if (py_r[i] < 0) begin
          px_r[i+1] <= px_r[i] - (py_r[i] >>> i);
          py_r[i+1] <= py_r[i] + (px_r[i] >>> i);
          pa_r[i+1] <= pa_r[i] - ATAN_TAB[i];
        end else begin
          px_r[i+1] <= px_r[i] + (py_r[i] >>> i);
          py_r[i+1] <= py_r[i] - (px_r[i] >>> i);
          pa_r[i+1] <= pa_r[i] + ATAN_TAB[i];
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_side = sd_r[NS-1];
  assign out_ang.yaw = ya_r[NS-1];
  assign out_ang.yaw_zero = yz_r[NS-1];
  assign out_ang.pitch = pa_r[NS-1];

endmodule

// ===== hdl/lsp_map.sv =====
// Angle to column and row mapping with a pipelined restoring divider for the row.
module lsp_map import lsp_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 2048
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  map_cfg_t cfg,
  input  logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  logic [$clog2(MAX_COLS+1)-1:0] cols,
  input  logic [FOV_W+$clog2(MAX_ROWS+1)-1:0] fov_rows,
  input  logic in_valid,
  input  side_t in_side,
  input  ang_t in_ang,
  output logic out_valid,
  output side_t out_side,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] out_col,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] out_row
);

  localparam int RCW = $clog2(MAX_ROWS+1);
  localparam int CW  = $clog2(MAX_COLS+1);
  localparam int QW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CVW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int TW  = ANG_W + 1;
  localparam int PW  = ANG_W + 16;
  localparam int NW  = 52;
  localparam int NRW = NW - 1 + RCW;
  localparam int DW  = NRW - 30;
  localparam int FRW = FOV_W + RCW;
  localparam int PCW = TW - 1 + CW;

  // stage 1
  logic v1_r;
  side_t s1_r;
  logic signed [TW-1:0] t1_r;
  logic signed [PW-1:0] p18_r;
  // stage 2
  logic v2_r;
  side_t s2_r;
  logic tneg2_r;
  logic [PCW-1:0] pc2_r;
  logic signed [NW-1:0] num2_r;
  // stage 3
  logic v3_r;
  side_t s3_r;
  logic [CVW-1:0] col3_r;
  logic neg3_r;
  logic [NRW-1:0] nr3_r;
  // stage 4
  logic v4_r;
  side_t s4_r;
  logic [CVW-1:0] col4_r;
  logic neg4_r;
  logic sat4_r;
  logic [FRW-1:0] rem4_r;
  // divider
  logic dv_r [QW];
  side_t dsd_r [QW];
  logic [CVW-1:0] dcol_r [QW];
  logic dneg_r [QW];
  logic dsat_r [QW];
  logic [FRW-1:0] drem_r [QW];
  logic [QW-1:0] dq_r [QW];
  // final
  logic vf_r;
  side_t sf_r;
  logic [CVW-1:0] colf_r;
  logic [QW-1:0] rowf_r;

  logic signed [TW-1:0] t_nxt;
  logic [CW+2:0] pc_sh;
  logic [CVW-1:0] col_nxt;
  logic [DW-1:0] dv;

  assign t_nxt = in_ang.yaw_zero ? TW'(HALF_TURN) : (TW'(HALF_TURN) - TW'(in_ang.yaw));
  assign pc_sh = pc2_r[PCW-1:31];
  assign dv = nr3_r[NRW-1:30];

  always_comb begin
    if (tneg2_r) begin
      col_nxt = '0;
    end else if (pc_sh > {3'b000, cols - 1'b1}) begin
      col_nxt = CVW'(cols - 1'b1);
    end else begin
      col_nxt = CVW'(pc_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vf_r <= dv_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_side;
      t1_r <= t_nxt;
      p18_r <= PW'(in_ang.pitch) * PW'(PITCH_SCALE);

      s2_r <= s1_r;
      tneg2_r <= t1_r < 0;
      pc2_r <= PCW'(t1_r[TW-2:0]) * PCW'(cols);
      num2_r <= (NW'(cfg.fov_dn) <<< 30) - NW'(p18_r);

      s3_r <= s2_r;
      col3_r <= col_nxt;
      neg3_r <= num2_r < 0;
      nr3_r <= NRW'(num2_r[NW-2:0]) * NRW'(rows);

      s4_r <= s3_r;
      col4_r <= col3_r;
      neg4_r <= neg3_r;
      sat4_r <= dv >= DW'(fov_rows);
      rem4_r <= dv[FRW-1:0];

      sf_r <= dsd_r[QW-1];
      colf_r <= dcol_r[QW-1];
      if (cfg.fov_zero || dneg_r[QW-1]) begin
        rowf_r <= '0;
      end else if (dsat_r[QW-1]) begin
        rowf_r <= QW'(rows - 1'b1);
      end else begin
        rowf_r <= dq_r[QW-1];
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic v_s, neg_s, sat_s;
    side_t sd_s;
    logic [CVW-1:0] col_s;
    logic [FRW-1:0] rem_s, dvs;
    logic [QW-1:0] q_s;
    if (j == 0) begin : g_src
      assign v_s = v4_r;
      assign sd_s = s4_r;
      assign col_s = col4_r;
      assign neg_s = neg4_r;
      assign sat_s = sat4_r;
      assign rem_s = rem4_r;
      assign q_s = '0;
    end else begin : g_src
      assign v_s = dv_r[j-1];
      assign sd_s = dsd_r[j-1];
      assign col_s = dcol_r[j-1];
      assign neg_s = dneg_r[j-1];
      assign sat_s = dsat_r[j-1];
      assign rem_s = drem_r[j-1];
      assign q_s = dq_r[j-1];
    end
    assign dvs = FRW'(cfg.fov) << (QW - 1 - j);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= v_s;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dsd_r[j] <= sd_s;
        dcol_r[j] <= col_s;
        dneg_r[j] <= neg_s;
        dsat_r[j] <= sat_s;
        if (rem_s >= dvs) begin
          drem_r[j] <= rem_s - dvs;
          dq_r[j] <= q_s | (QW'(1) << (QW - 1 - j));
        end else begin
          drem_r[j] <= rem_s;
          dq_r[j] <= q_s;
        end
      end
    end
  end

  assign out_valid = vf_r;
  assign out_side = sf_r;
  assign out_col = colf_r;
  assign out_row = rowf_r;

endmodule
